// ===== src/fdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared widths, request codes, limits and controller types for the
// fractional delay FIR filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

   localparam int SAMPLE_WIDTH      = 16;
   localparam int COEFF_WIDTH       = 16;
   localparam int OP_WIDTH          = 2;
   localparam int TAP_IDX_WIDTH     = 8;
   localparam int OUT_IDX_WIDTH     = 9;
   localparam int SHIFT_WIDTH       = 5;
   localparam int TAP_COUNT_DEFAULT = 256;
   localparam int FRAME_LENGTH      = 512;
   localparam int LEAD_OFFSET       = TAP_COUNT_DEFAULT / 2;

   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = SHIFT_WIDTH'(15);

   localparam logic [OP_WIDTH-1:0] OP_PUSH  = OP_WIDTH'(0);
   localparam logic [OP_WIDTH-1:0] OP_FLUSH = OP_WIDTH'(1);
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = OP_WIDTH'(2);

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DRAIN
   } fdf_state_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic finish;
   } fdf_cmd_type;

   typedef struct packed {
      logic start;
      logic tap_last;
      logic pipe_busy;
      logic out_free;
   } fdf_status_type;

endpackage
`default_nettype wire

// ===== src/fdf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/fdf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdf_ctrl
// Controller: takes requests when idle, walks the taps, waits for the
// multiply-accumulate pipeline to drain and hands the result over.
// ----------------------------------------------------------------------------
module fdf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire fdf_pkg::fdf_status_type status,
   output fdf_pkg::fdf_cmd_type         cmd
);
   import fdf_pkg::*;

   fdf_state_type state_ff;
   fdf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_CALC: begin
            cmd.step = 1'b1;
         end
         ST_DRAIN: begin
            cmd.finish = !status.pipe_busy && status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/fdf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdf_datapath
// Delay line and coefficient memories, frame counters, one shared
// multiply-accumulate pipeline, shift, saturation and the result register.
// ----------------------------------------------------------------------------
module fdf_datapath #(
   parameter int TAP_COUNT = fdf_pkg::TAP_COUNT_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire fdf_pkg::fdf_cmd_type                    cmd,
   output fdf_pkg::fdf_status_type                      status,
   input  wire logic [fdf_pkg::OP_WIDTH-1:0]            req_op,
   input  wire logic signed [fdf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                                    req_frame_start,
   input  wire logic [fdf_pkg::TAP_IDX_WIDTH-1:0]       req_tap_index,
   input  wire logic signed [fdf_pkg::COEFF_WIDTH-1:0]  req_coefficient,
   input  wire logic                                    csr_wr_en,
   input  wire logic [fdf_pkg::SHIFT_WIDTH-1:0]         csr_wr_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [fdf_pkg::SAMPLE_WIDTH-1:0]      rsp_out_sample,
   output logic [fdf_pkg::OUT_IDX_WIDTH-1:0]            rsp_out_index,
   output logic                                         rsp_saturated
);
   import fdf_pkg::*;

   localparam int ADDR_W  = $clog2(TAP_COUNT);
   localparam int LIMIT   = FRAME_LENGTH + TAP_COUNT;
   localparam int CNT_W   = $clog2(LIMIT + 1);
   localparam int SUM_W   = $clog2(LIMIT + LEAD_OFFSET + 1);
   localparam int TIDX_W  = ADDR_W + TAP_IDX_WIDTH;
   localparam int PROD_W  = SAMPLE_WIDTH + COEFF_WIDTH;
   localparam int ACC_W   = PROD_W + ADDR_W;

   // frame state
   logic [ADDR_W-1:0]        wp_ff, wp_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SHIFT_WIDTH-1:0]   shift_ff;
   logic [OUT_IDX_WIDTH-1:0] idx_ff;
   logic [TAP_COUNT-1:0]     cvalid_ff;

   // tap walk and pipeline
   logic [ADDR_W-1:0]        k_ff;
   logic [ADDR_W-1:0]        pos_ff;
   logic                     rd_v_ff, prod_v_ff;
   logic                     cval_ff, dval_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // result register
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]  out_sample_ff;
   logic [OUT_IDX_WIDTH-1:0]        out_index_ff;
   logic                            saturated_ff;

   logic                     is_push, is_fill, fresh;
   logic [ADDR_W-1:0]        wp_base;
   logic [CNT_W-1:0]         cnt_base;
   logic [SUM_W-1:0]         lead_sum;
   logic                     emit;
   logic [TIDX_W-1:0]        tap_wide;
   logic                     coef_wr;
   logic [SAMPLE_WIDTH-1:0]  push_value;
   logic [SAMPLE_WIDTH-1:0]  dl_rd_data;
   logic [COEFF_WIDTH-1:0]   cf_rd_data;
   logic signed [SAMPLE_WIDTH-1:0] d_op;
   logic signed [COEFF_WIDTH-1:0]  c_op;
   logic signed [ACC_W-1:0]  shifted;

   assign is_push  = (req_op == OP_PUSH);
   assign is_fill  = is_push || (req_op == OP_FLUSH);
   assign fresh    = is_push && req_frame_start;
   assign wp_base  = fresh ? '0 : wp_ff;
   assign cnt_base = fresh ? '0 : cnt_ff;

   always_comb begin
      wp_in  = (wp_base == ADDR_W'(TAP_COUNT - 1)) ? '0 : wp_base + 1'b1;
      cnt_in = (cnt_base == CNT_W'(LIMIT)) ? cnt_base : cnt_base + 1'b1;
   end

   // output index = count + lead - taps, valid only inside the frame
   assign lead_sum = SUM_W'(cnt_in) + SUM_W'(LEAD_OFFSET);
   assign emit     = is_fill
                     && (lead_sum >= SUM_W'(TAP_COUNT))
                     && ((lead_sum - SUM_W'(TAP_COUNT)) < SUM_W'(FRAME_LENGTH))
                     && (cnt_in < CNT_W'(LIMIT));

   assign tap_wide   = TIDX_W'(req_tap_index);
   assign coef_wr    = cmd.capture && (req_op == OP_LOAD)
                       && (tap_wide < TIDX_W'(TAP_COUNT));
   assign push_value = is_push ? req_sample : '0;

   fdf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (TAP_COUNT)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.capture && is_fill),
      .wr_addr (wp_base),
      .wr_data (push_value),
      .rd_addr (pos_ff),
      .rd_data (dl_rd_data)
   );

   fdf_ram #(
      .WIDTH (COEFF_WIDTH),
      .DEPTH (TAP_COUNT)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (tap_wide[ADDR_W-1:0]),
      .wr_data (req_coefficient),
      .rd_addr (k_ff),
      .rd_data (cf_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         cnt_ff    <= '0;
         shift_ff  <= SHIFT_RESET;
         cvalid_ff <= '0;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
         if (cmd.capture && is_fill) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
         end
         if (coef_wr) begin
            cvalid_ff[tap_wide[ADDR_W-1:0]] <= 1'b1;
         end
         rd_v_ff   <= cmd.step;
         prod_v_ff <= rd_v_ff;
      end
   end

   // slot is filled in this frame once the count has passed it
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         k_ff   <= '0;
         pos_ff <= wp_in;
         acc_ff <= '0;
         idx_ff <= OUT_IDX_WIDTH'(lead_sum - SUM_W'(TAP_COUNT));
      end else begin
         if (cmd.step) begin
            k_ff   <= k_ff + 1'b1;
            pos_ff <= (pos_ff == ADDR_W'(TAP_COUNT - 1)) ? '0 : pos_ff + 1'b1;
         end
         if (prod_v_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      cval_ff <= cvalid_ff[k_ff];
      dval_ff <= (cnt_ff > CNT_W'(pos_ff));
      prod_ff <= d_op * c_op;
   end

   assign d_op = dval_ff ? $signed(dl_rd_data) : '0;
   assign c_op = cval_ff ? $signed(cf_rd_data) : '0;

   assign shifted = acc_ff >>> shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_index_ff <= idx_ff;
         if (shifted > ACC_W'(SAMPLE_MAX)) begin
            out_sample_ff <= SAMPLE_MAX;
            saturated_ff  <= 1'b1;
         end else if (shifted < ACC_W'(SAMPLE_MIN)) begin
            out_sample_ff <= SAMPLE_MIN;
            saturated_ff  <= 1'b1;
         end else begin
            out_sample_ff <= shifted[SAMPLE_WIDTH-1:0];
            saturated_ff  <= 1'b0;
         end
      end
   end

   always_comb begin
      status.start     = emit;
      status.tap_last  = (k_ff == ADDR_W'(TAP_COUNT - 1));
      status.pipe_busy = rd_v_ff || prod_v_ff;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_out_index  = out_index_ff;
   assign rsp_saturated  = saturated_ff;

endmodule
`default_nettype wire

// ===== src/fir_fractional_delay_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// timing: a load, an ignored code or a push that yields no output is taken in the idle state
// and leaves it idle; a push that yields an output moves on through the tap walk, the pipeline
// drain and the result register to rsp_valid; the single multiply-accumulate unit visits one tap a cycle
// requests are held off with req_stall until the result is handed over, longer if rsp_stall holds
// reset: synchronous, clears counters, coefficient valid bits and handshake state,
// sets output_shift to 15; no clearing pass, the block takes requests right away
// ----------------------------------------------------------------------------
// fir_fractional_delay_filter_top
// Direct-form FIR filter over frames with a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module fir_fractional_delay_filter_top #(
   parameter int TAP_COUNT = fdf_pkg::TAP_COUNT_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [fdf_pkg::OP_WIDTH-1:0]            req_op,
   input  wire logic signed [fdf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                                    req_frame_start,
   input  wire logic [fdf_pkg::TAP_IDX_WIDTH-1:0]       req_tap_index,
   input  wire logic signed [fdf_pkg::COEFF_WIDTH-1:0]  req_coefficient,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [fdf_pkg::SAMPLE_WIDTH-1:0]      rsp_out_sample,
   output logic [fdf_pkg::OUT_IDX_WIDTH-1:0]            rsp_out_index,
   output logic                                         rsp_saturated,
   input  wire logic                                    csr_wr_en,
   input  wire logic [fdf_pkg::SHIFT_WIDTH-1:0]         csr_wr_data
);
   import fdf_pkg::*;

   fdf_cmd_type    cmd;
   fdf_status_type status;

   fdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdf_datapath #(
      .TAP_COUNT (TAP_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .req_tap_index   (req_tap_index),
      .req_coefficient (req_coefficient),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_index   (rsp_out_index),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
`default_nettype wire

// ===== src/fdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdf_checker
// Port-level checks of the filter top, attached by bind.
// ----------------------------------------------------------------------------
module fdf_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_stall,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_stall,
   input wire logic signed [fdf_pkg::SAMPLE_WIDTH-1:0] rsp_out_sample,
   input wire logic [fdf_pkg::OUT_IDX_WIDTH-1:0]       rsp_out_index,
   input wire logic                                    rsp_saturated
);
   import fdf_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_sample) && $stable(rsp_out_index))
      else $error("stalled response payload changed");

   // a new result only appears at the end of a tap walk, while requests are held off
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a tap walk");

   // clipping flag only with a full-scale sample
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_out_sample == SAMPLE_MAX)
                                     || (rsp_out_sample == SAMPLE_MIN))
      else $error("saturation flag with in-range sample");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind fir_fractional_delay_filter_top fdf_checker u_fdf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_sample (rsp_out_sample),
   .rsp_out_index  (rsp_out_index),
   .rsp_saturated  (rsp_saturated)
);
`default_nettype wire

// ===== sim/tb_fir_fractional_delay_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_fractional_delay_filter_top
// Self-checking bench for the framed 256-tap FIR filter. A queue-fed driver
// offers push, flush, load and unused requests with random gaps. A monitor
// forms the expected filter outputs from its own tap and delay-line copies and
// compares each accepted output against them. Phases run at several output
// shift settings, and the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_fir_fractional_delay_filter_top;
   import fdf_pkg::*;

   localparam int TAPS        = TAP_COUNT_DEFAULT;
   localparam int COUNT_LIMIT = FRAME_LENGTH + TAPS;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = OP_WIDTH'(3);
   localparam int DRAIN_WAIT  = 300;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 2500;
   localparam int HOLD_AT     = 40;

   typedef struct {
      logic [OP_WIDTH-1:0]            op;
      logic signed [SAMPLE_WIDTH-1:0] smp;
      logic                           frame_start;
      logic [TAP_IDX_WIDTH-1:0]       tap;
      logic signed [COEFF_WIDTH-1:0]  coef;
      bit                             drain_first;
   } filter_req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_sample;
      logic [OUT_IDX_WIDTH-1:0]       out_index;
      logic                           saturated;
   } filter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic [OP_WIDTH-1:0]             req_op          = '0;
   logic signed [SAMPLE_WIDTH-1:0]  req_sample      = '0;
   logic                            req_frame_start = 1'b0;
   logic [TAP_IDX_WIDTH-1:0]        req_tap_index   = '0;
   logic signed [COEFF_WIDTH-1:0]   req_coefficient = '0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_out_sample;
   logic [OUT_IDX_WIDTH-1:0]        rsp_out_index;
   logic                            rsp_saturated;
   logic                            csr_wr_en       = 1'b0;
   logic [SHIFT_WIDTH-1:0]          csr_wr_data     = '0;

   // filter state mirrored for prediction
   logic signed [COEFF_WIDTH-1:0]  tap_coef  [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] line_hist [TAPS];
   logic [TAP_IDX_WIDTH-1:0]       line_wp;
   int unsigned                    frame_pushes;
   logic [SHIFT_WIDTH-1:0]         shift_cfg;

   filter_req_type pending_reqs[$];
   filter_out_type expected_outputs[$];

   logic req_taken = 1'b0;
   int   mismatch_count = 0;
   int   outputs_seen = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   logic quiet;

   assign quiet = (cycle_count >= 40000) && (cycle_count < 90000);

   fir_fractional_delay_filter_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .req_tap_index   (req_tap_index),
      .req_coefficient (req_coefficient),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_index   (rsp_out_index),
      .rsp_saturated   (rsp_saturated),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   // one sample into the delay line, possibly yielding an output
   task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
      longint         acc;
      longint         r;
      int unsigned    idx;
      filter_out_type res;
      line_hist[line_wp] = v;
      line_wp = line_wp + 1'b1;
      if (frame_pushes < COUNT_LIMIT) frame_pushes++;
      if (frame_pushes + LEAD_OFFSET < TAPS) return;
      idx = frame_pushes + LEAD_OFFSET - TAPS;
      if (idx >= FRAME_LENGTH || frame_pushes >= COUNT_LIMIT) return;
      acc = 0;
      // oldest sample meets tap 0
      for (int k = 0; k < TAPS; k++) begin
         acc += longint'(tap_coef[k]) * longint'(line_hist[TAP_IDX_WIDTH'(line_wp + k)]);
      end
      r = acc >>> shift_cfg;
      res.saturated = 1'b0;
      if (r > longint'(SAMPLE_MAX)) begin
         r = longint'(SAMPLE_MAX);
         res.saturated = 1'b1;
      end
      if (r < longint'(SAMPLE_MIN)) begin
         r = longint'(SAMPLE_MIN);
         res.saturated = 1'b1;
      end
      res.out_sample = r[SAMPLE_WIDTH-1:0];
      res.out_index  = idx[OUT_IDX_WIDTH-1:0];
      expected_outputs.push_back(res);
   endtask

   task automatic predict_request(input logic [OP_WIDTH-1:0] op,
                                  input logic signed [SAMPLE_WIDTH-1:0] smp,
                                  input logic fs,
                                  input logic [TAP_IDX_WIDTH-1:0] tap,
                                  input logic signed [COEFF_WIDTH-1:0] coef);
      case (op)
         OP_PUSH: begin
            if (fs) begin
               for (int i = 0; i < TAPS; i++) line_hist[i] = '0;
               line_wp = '0;
               frame_pushes = 0;
            end
            push_sample(smp);
         end
         OP_FLUSH: push_sample('0);
         OP_LOAD: tap_coef[tap] = coef;
         default: ;
      endcase
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_WIDTH'($signed($urandom_range(64)) - 32);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // spread of magnitudes so that both clipped and clean outputs occur
   function automatic logic signed [COEFF_WIDTH-1:0] rand_coef();
      logic signed [COEFF_WIDTH-1:0] c;
      c = COEFF_WIDTH'($urandom);
      return c >>> $urandom_range(10);
   endfunction

   task automatic add_req(input logic [OP_WIDTH-1:0] op,
                          input logic signed [SAMPLE_WIDTH-1:0] smp,
                          input logic fs,
                          input logic [TAP_IDX_WIDTH-1:0] tap,
                          input logic signed [COEFF_WIDTH-1:0] coef,
                          input bit drain);
      filter_req_type r;
      r.op = op;
      r.smp = smp;
      r.frame_start = fs;
      r.tap = tap;
      r.coef = coef;
      r.drain_first = drain;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_shift(input logic [SHIFT_WIDTH-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      shift_cfg = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // driver: holds a stalled request, otherwise offers the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_taken) void'(pending_reqs.pop_front());
         if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 16) &&
             !(pending_reqs[0].drain_first && expected_outputs.size() != 0)) begin
            req_op          <= pending_reqs[0].op;
            req_sample      <= pending_reqs[0].smp;
            req_frame_start <= pending_reqs[0].frame_start;
            req_tap_index   <= pending_reqs[0].tap;
            req_coefficient <= pending_reqs[0].coef;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && outputs_seen == HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 16);
      end
   end

   // monitor: checks outputs first, then predicts from the accepted request
   always @(posedge clock) begin
      filter_out_type exp_out;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            outputs_seen++;
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected output sample %0d index %0d saturated %0b", $time,
                        rsp_out_sample, rsp_out_index, rsp_saturated);
            end else begin
               exp_out = expected_outputs.pop_front();
               if (rsp_out_sample !== exp_out.out_sample) begin
                  mismatch_count++;
                  $display("%0t: out_sample expected %0d actual %0d", $time,
                           exp_out.out_sample, rsp_out_sample);
               end
               if (rsp_out_index !== exp_out.out_index) begin
                  mismatch_count++;
                  $display("%0t: out_index expected %0d actual %0d", $time,
                           exp_out.out_index, rsp_out_index);
               end
               if (rsp_saturated !== exp_out.saturated) begin
                  mismatch_count++;
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           exp_out.saturated, rsp_saturated);
               end
            end
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            predict_request(req_op, req_sample, req_frame_start, req_tap_index,
                            req_coefficient);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fir_fractional_delay_filter_top: mismatch");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TAPS; i++) begin
         tap_coef[i]  = '0;
         line_hist[i] = '0;
      end
      line_wp = '0;
      frame_pushes = 0;
      shift_cfg = SHIFT_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every code, ignored fields
      add_req(OP_LOAD, SAMPLE_MIN, 1'b0, 8'd0, SAMPLE_MAX, 1'b0);
      add_req(OP_LOAD, SAMPLE_MAX, 1'b0, 8'd255, SAMPLE_MIN, 1'b0);
      add_req(OP_LOAD, '0, 1'b1, 8'd128, 16'sh4000, 1'b0);
      add_req(OP_UNUSED, SAMPLE_MAX, 1'b1, 8'hff, SAMPLE_MIN, 1'b0);
      add_req(OP_PUSH, SAMPLE_MAX, 1'b1, 8'h00, '0, 1'b0);
      add_req(OP_PUSH, SAMPLE_MIN, 1'b0, 8'hff, SAMPLE_MAX, 1'b0);
      add_req(OP_PUSH, '0, 1'b0, 8'h55, 16'sh5555, 1'b0);
      add_req(OP_FLUSH, SAMPLE_MAX, 1'b1, 8'haa, 16'shaaaa, 1'b0);
      add_req(OP_PUSH, -16'sd1, 1'b0, 8'h0f, -16'sd1, 1'b0);
      add_req(OP_UNUSED, '0, 1'b0, 8'h00, '0, 1'b0);
      add_req(OP_PUSH, SAMPLE_MIN, 1'b1, 8'hf0, SAMPLE_MAX, 1'b0);
      add_req(OP_FLUSH, '0, 1'b0, 8'h00, '0, 1'b0);
      add_req(OP_LOAD, SAMPLE_MIN, 1'b1, 8'd127, -16'sd1, 1'b1);
      add_req(OP_LOAD, '0, 1'b0, 8'd1, 16'sd1, 1'b0);
      add_req(OP_PUSH, 16'sd1, 1'b0, 8'h00, '0, 1'b0);
      add_req(OP_LOAD, '0, 1'b0, 8'd128, '0, 1'b0);
      wait_for_drain();
      @(posedge clock);

      // full frame at reset shift: all taps, every output index, push count saturation
      for (int t = 0; t < TAPS; t++)
         add_req(OP_LOAD, rand_sample(), 1'($urandom), 8'(t), rand_coef(), 1'b0);
      add_req(OP_PUSH, rand_sample(), 1'b1, 8'($urandom), rand_coef(), 1'b0);
      for (int n = 1; n < COUNT_LIMIT + 12; n++) begin
         if ($urandom_range(39) == 0)
            add_req(OP_LOAD, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(), 1'b0);
         if ($urandom_range(59) == 0)
            add_req(OP_UNUSED, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(), 1'b0);
         if (n < 620)
            add_req(OP_PUSH, rand_sample(), 1'b0, 8'($urandom), rand_coef(), n == 300);
         else
            add_req(OP_FLUSH, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(), 1'b0);
      end
      wait_for_drain();

      // no shift: mostly clipped
      write_shift('0);
      for (int n = 0; n < 40; n++)
         add_req(OP_LOAD, rand_sample(), 1'b0, 8'($urandom), rand_coef(), 1'b0);
      add_req(OP_PUSH, rand_sample(), 1'b1, 8'($urandom), rand_coef(), 1'b0);
      for (int n = 0; n < 170; n++)
         add_req(OP_PUSH, rand_sample(), 1'b0, 8'($urandom), rand_coef(), 1'b0);
      wait_for_drain();

      // widest shift, flushes and restarts mixed in
      write_shift({SHIFT_WIDTH{1'b1}});
      add_req(OP_PUSH, rand_sample(), 1'b1, 8'($urandom), rand_coef(), 1'b0);
      for (int n = 0; n < 150; n++) begin
         if ($urandom_range(4) == 0)
            add_req(OP_FLUSH, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(), 1'b0);
         else
            add_req(OP_PUSH, rand_sample(), $urandom_range(99) == 0, 8'($urandom),
                    rand_coef(), 1'b0);
      end
      wait_for_drain();

      // random shift, fully random requests continuing the frame
      write_shift(SHIFT_WIDTH'($urandom_range(30, 1)));
      for (int n = 0; n < 120; n++) begin
         case ($urandom_range(9))
            0: add_req(OP_LOAD, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(),
                       $urandom_range(49) == 0);
            1: add_req(OP_FLUSH, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(), 1'b0);
            2: add_req(OP_UNUSED, rand_sample(), 1'($urandom), 8'($urandom), rand_coef(),
                       1'b0);
            default: add_req(OP_PUSH, rand_sample(), $urandom_range(59) == 0, 8'($urandom),
                             rand_coef(), $urandom_range(49) == 0);
         endcase
      end
      wait_for_drain();

      if (mismatch_count == 0)
         $display("fir_fractional_delay_filter_top: match");
      else
         $display("fir_fractional_delay_filter_top: mismatch");
      $finish;
   end

endmodule
